// File: rtl/dhv_pkg.sv
// Shared types, constants and the payload type lookup for the DoIP header validator.
`timescale 1ns / 1ps

package dhv_pkg;

  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] HDR_BYTES   = 4'd8;
  localparam logic [POS_W-1:0] POS_VER     = 4'd0;
  localparam logic [POS_W-1:0] POS_INV_VER = 4'd1;
  localparam logic [POS_W-1:0] POS_TYPE_HI = 4'd2;
  localparam logic [POS_W-1:0] POS_TYPE_LO = 4'd3;

  localparam logic [7:0] INV_MATCH = 8'hff;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_TYPE    = 2'd2;
  localparam logic [1:0] ERR_SHORT   = 2'd3;

  localparam logic [15:0] TYPE_GEN_LO  = 16'h0000;
  localparam logic [15:0] TYPE_GEN_HI  = 16'h0008;
  localparam logic [15:0] TYPE_DIAG_LO = 16'h4001;
  localparam logic [15:0] TYPE_DIAG_HI = 16'h4004;
  localparam logic [15:0] TYPE_MSG_LO  = 16'h8001;
  localparam logic [15:0] TYPE_MSG_HI  = 16'h8003;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  error_code;
    logic [15:0] payload_type_seen;
    logic [31:0] declared_length;
  } dhv_result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       err;
  } dhv_status_t;

  // generic range starts at zero, so only its upper bound needs a compare
  function automatic logic type_is_known(input logic [15:0] t);
    logic ok;
    ok = (t <= TYPE_GEN_HI) ||
         ((t >= TYPE_DIAG_LO) && (t <= TYPE_DIAG_HI)) ||
         ((t >= TYPE_MSG_LO) && (t <= TYPE_MSG_HI));
    return ok;
  endfunction

endpackage

// File: rtl/doip_header_validator.sv
// Top level of the DoIP generic header validator.
//
//   channel  direction  ports                          payload
//   in       sink       in_tvalid/in_tready/in_tdata   data_byte, end_of_message on in_tlast
//   out      source     out_tvalid/out_tready/out_tdata verdict, type, length
//
// One byte is taken per cycle while in_tready is high; the verdict appears in the cycle after the last byte.
// All header state updates in the same cycle the byte is accepted.
// Reset is synchronous, active low, and clears the parser and the result valid flag.
// in_tready drops only while a verdict waits and out_tready is low.
`timescale 1ns / 1ps

module doip_header_validator
  import dhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [0] accepted, [2:1] error_code,
                                  // [18:3] payload_type_seen, [50:19] declared_length, rest 0
);

  logic        step;
  logic        res_valid;
  logic        room;
  dhv_result_t res;
  dhv_result_t held;
  dhv_status_t status;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  dhv_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .res_valid      (res_valid),
    .res            (res),
    .status         (status)
  );

  dhv_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .load_res (res),
    .room     (room),
    .valid    (out_tvalid),
    .take     (out_tready),
    .res      (held)
  );

  assign out_tdata = {5'b0, held.declared_length, held.payload_type_seen,
                      held.error_code, held.accepted};

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    status.pos <= HDR_BYTES)
    else $error("byte position past header length");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_tlast |=> (status.pos == '0) && (status.err == ERR_NONE) && out_tvalid)
    else $error("last byte did not clear state or post a verdict");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status.err != ERR_NONE) && !(step && in_tlast) |=> status.err == $past(status.err))
    else $error("latched error changed inside a message");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == ERR_NONE)))
    else $error("accepted flag disagrees with error code");

endmodule

// File: rtl/dhv_parser.sv
// Header parse state and per-byte update, producing the verdict on the last byte.
`timescale 1ns / 1ps

module dhv_parser
  import dhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        res_valid,
  output dhv_result_t res,
  output dhv_status_t status
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       ver_r, ver_nxt;
  logic [15:0]      typ_r, typ_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [1:0]       code;

  always_comb begin
    ver_nxt = ver_r;
    typ_nxt = typ_r;
    len_nxt = len_r;
    err_nxt = err_r;
    if ((err_r == ERR_NONE) && (pos_r < HDR_BYTES)) begin
      case (pos_r)
        POS_VER: begin
          ver_nxt = data_byte;
        end
        POS_INV_VER: begin
          if ((ver_r ^ data_byte) != INV_MATCH) err_nxt = ERR_VERSION;
        end
        POS_TYPE_HI: begin
          typ_nxt = {8'h00, data_byte};
        end
        POS_TYPE_LO: begin
          typ_nxt = {typ_r[7:0], data_byte};
          if (!type_is_known({typ_r[7:0], data_byte})) err_nxt = ERR_TYPE;
        end
        default: begin
          len_nxt = {len_r[23:0], data_byte};
        end
      endcase
    end
    pos_nxt = (pos_r < HDR_BYTES) ? pos_r + 4'd1 : pos_r;

    code = err_nxt;
    if ((err_nxt == ERR_NONE) && (pos_nxt < HDR_BYTES)) code = ERR_SHORT;
  end

  assign res_valid             = step && end_of_message;
  assign res.accepted          = (code == ERR_NONE);
  assign res.error_code        = code;
  assign res.payload_type_seen = typ_nxt;
  assign res.declared_length   = len_nxt;
  assign status.pos            = pos_r;
  assign status.err            = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ver_r <= '0;
      typ_r <= '0;
      len_r <= '0;
      err_r <= ERR_NONE;
    end else if (step) begin
      if (end_of_message) begin
        pos_r <= '0;
        ver_r <= '0;
        typ_r <= '0;
        len_r <= '0;
        err_r <= ERR_NONE;
      end else begin
        pos_r <= pos_nxt;
        ver_r <= ver_nxt;
        typ_r <= typ_nxt;
        len_r <= len_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

// File: rtl/dhv_out_reg.sv
// Result register holding one verdict until the downstream side takes it.
`timescale 1ns / 1ps

module dhv_out_reg
  import dhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  dhv_result_t load_res,
  output logic        room,
  output logic        valid,
  input  logic        take,
  output dhv_result_t res
);

  logic        valid_r;
  dhv_result_t res_r;

  assign room  = !valid_r || take;
  assign valid = valid_r;
  assign res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule
